FILE: rtl/core/bmvg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and face table of the box mesh vertex generator.
package bmvg_pkg;

   localparam int DEF_MAX_SEGMENTS = 64;

   localparam int EXT_W       = 16;
   localparam int SEG_CFG_W   = 7;
   localparam int COLOR_W     = 3;
   localparam int FACE_W      = 3;
   localparam int NORMAL_W    = 3;
   localparam int POS_W       = 16;
   localparam int TEX_W       = 16;
   localparam int INDEX_W     = 16;
   localparam int QUO_W       = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [EXT_W-1:0]     EXT_RESET      = 16'd256;
   localparam logic [SEG_CFG_W-1:0] SEG_RESET      = 7'd1;
   localparam logic [COLOR_W-1:0]   COLOR_RESET    = 3'd0;
   localparam logic [COLOR_W-1:0]   COLOR_GRAY     = 3'd6;
   localparam logic [COLOR_W-1:0]   COLOR_PER_FACE = 3'd6;
   localparam logic [FACE_W-1:0]    FACE_FIRST     = 3'd0;
   localparam logic [FACE_W-1:0]    FACE_LAST      = 3'd5;
   localparam logic [NORMAL_W-1:0]  NORMAL_NEG_Z   = 3'd5;
   localparam logic [TEX_W-1:0]     TEX_ONE        = 16'h8000;
   localparam logic [POS_W-1:0]     POS_MAX        = 16'h7FFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOX_WIDTH   = 3'd0,
      CSR_BOX_HEIGHT  = 3'd1,
      CSR_BOX_DEPTH   = 3'd2,
      CSR_SEGMENTS_X  = 3'd3,
      CSR_SEGMENTS_Y  = 3'd4,
      CSR_SEGMENTS_Z  = 3'd5,
      CSR_COLOR_COUNT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      axis_type ua;
      axis_type va;
      axis_type wa;
      logic     u_neg;
      logic     v_neg;
      logic     w_neg;
   } face_desc_type;

   typedef enum logic [1:0] {
      OP_POS_U = 2'd0,
      OP_POS_V = 2'd1,
      OP_TEX_U = 2'd2,
      OP_TEX_V = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MISC,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic   capture;
      logic   load;
      logic   misc;
      logic   div_start;
      logic   div_store;
      logic   commit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

   // Axis permutation and direction signs of each face, +x first and -z last.
   function automatic face_desc_type face_lookup(input logic [FACE_W-1:0] face);
      face_desc_type d;
      case (face)
         3'd1:    d = '{ua: AXIS_Z, va: AXIS_Y, wa: AXIS_X, u_neg: 1'b1, v_neg: 1'b1, w_neg: 1'b1};
         3'd2:    d = '{ua: AXIS_X, va: AXIS_Z, wa: AXIS_Y, u_neg: 1'b0, v_neg: 1'b0, w_neg: 1'b0};
         3'd3:    d = '{ua: AXIS_X, va: AXIS_Z, wa: AXIS_Y, u_neg: 1'b0, v_neg: 1'b1, w_neg: 1'b1};
         3'd4:    d = '{ua: AXIS_X, va: AXIS_Y, wa: AXIS_Z, u_neg: 1'b0, v_neg: 1'b1, w_neg: 1'b0};
         3'd5:    d = '{ua: AXIS_X, va: AXIS_Y, wa: AXIS_Z, u_neg: 1'b1, v_neg: 1'b1, w_neg: 1'b1};
         default: d = '{ua: AXIS_Z, va: AXIS_Y, wa: AXIS_X, u_neg: 1'b0, v_neg: 1'b1, w_neg: 1'b0};
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/core/bmvg_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
module bmvg_divider #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            dividend,
   input  logic [DEN_W-1:0]            divisor,
   output logic                        busy,
   output logic [bmvg_pkg::QUO_W-1:0]  quotient
);
   import bmvg_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] ds_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] count_ff;

   // The caller guarantees the quotient fits QUO_W bits, so the remainder
   // starts below twice the first shifted divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_W'(QUO_W);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         ds_ff  <= NUM_W'(divisor) << (QUO_W - 1);
         quo_ff <= '0;
      end else if (count_ff != '0) begin
         if (rem_ff >= ds_ff) begin
            rem_ff <= rem_ff - ds_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         ds_ff <= ds_ff >> 1;
      end
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/bmvg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences one vertex through the datapath.
module bmvg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmvg_pkg::status_type   status,
   output bmvg_pkg::cmd_type      cmd
);
   import bmvg_pkg::*;

   ctrl_state_type state_ff, state_in;
   op_type         op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_POS_U;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MISC;
         end
         ST_MISC: begin
            cmd.misc = 1'b1;
            op_in    = OP_POS_U;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               cmd.div_store = 1'b1;
               case (op_ff)
                  OP_POS_U: begin
                     op_in    = OP_POS_V;
                     state_in = ST_DIV_INIT;
                  end
                  OP_POS_V: begin
                     op_in    = OP_TEX_U;
                     state_in = ST_DIV_INIT;
                  end
                  OP_TEX_U: begin
                     op_in    = OP_TEX_V;
                     state_in = ST_DIV_INIT;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            // Wait until the output register is empty or being emptied.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/bmvg_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, walk state, vertex arithmetic and output register.
module bmvg_datapath #(
   parameter int MAX_SEGMENTS = bmvg_pkg::DEF_MAX_SEGMENTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmvg_pkg::cmd_type                    cmd,
   output bmvg_pkg::status_type                 status,
   input  logic                                 req_restart,
   input  logic                                 csr_write,
   input  logic [bmvg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bmvg_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic [bmvg_pkg::NORMAL_W-1:0]        rsp_normal_code,
   output logic [bmvg_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [bmvg_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic [bmvg_pkg::COLOR_W-1:0]         rsp_color_slot,
   output logic                                 rsp_quad_valid,
   output logic [bmvg_pkg::INDEX_W-1:0]         rsp_index_a,
   output logic [bmvg_pkg::INDEX_W-1:0]         rsp_index_b,
   output logic                                 rsp_last_vertex
);
   import bmvg_pkg::*;

   localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int DEN_W  = SEG_W + 1;
   localparam int NUM_W  = SEG_W + QUO_W;
   localparam int PROD_W = SEG_W + EXT_W;
   localparam int ROW_W  = 2 * SEG_W + 2;
   localparam logic [SEG_CFG_W-1:0] MAX_SEG_CFG = SEG_CFG_W'(MAX_SEGMENTS);

   function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_CFG_W-1:0] s);
      logic [SEG_W-1:0] r;
      if (s == '0) begin
         r = SEG_W'(1);
      end else if (s > MAX_SEG_CFG) begin
         r = SEG_W'(MAX_SEGMENTS);
      end else begin
         r = s[SEG_W-1:0];
      end
      return r;
   endfunction

   // Signed result of a rounded magnitude, saturated to the Q8.8 range.
   function automatic logic [POS_W-1:0] signed_pos(input logic [QUO_W-1:0] q,
                                                   input logic neg);
      logic [QUO_W-1:0] qn;
      logic [POS_W-1:0] r;
      qn = -q;
      if (neg) begin
         r = qn[POS_W-1:0];
      end else if (q > QUO_W'(POS_MAX)) begin
         r = POS_MAX;
      end else begin
         r = q[POS_W-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [EXT_W-1:0]     width_ff, height_ff, depth_ff;
   logic [SEG_CFG_W-1:0] segs_x_ff, segs_y_ff, segs_z_ff;
   logic [COLOR_W-1:0]   color_count_ff;

   // Walk state.
   logic [FACE_W-1:0]  face_ff;
   logic [SEG_W-1:0]   column_ff, row_ff;
   logic [INDEX_W-1:0] base_ff;

   // Item registers.
   logic               restart_ff;
   logic [FACE_W-1:0]  face_cur_ff;
   face_desc_type      desc_ff;
   logic [SEG_W-1:0]   gx_ff, gy_ff, ix_ff, iy_ff;
   logic [INDEX_W-1:0] base_cur_ff;
   logic [EXT_W-1:0]   e_u_ff, e_v_ff, e_w_ff;

   logic [SEG_W-1:0]    diff_u_ff, diff_v_ff;
   logic                neg_u_ff, neg_v_ff;
   logic [POS_W-1:0]    pos_w_ff;
   logic [NORMAL_W-1:0] normal_ff;
   logic                quad_ff, last_ff;
   logic [INDEX_W-1:0]  index_a_ff, index_b_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [FACE_W-1:0]   next_face_ff;
   logic [SEG_W-1:0]    next_col_ff, next_row_ff;
   logic [INDEX_W-1:0]  next_base_ff;

   logic [POS_W-1:0] pos_u_ff, pos_v_ff;
   logic [TEX_W-1:0] tex_u_ff, tex_v_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    out_pos_x_ff, out_pos_y_ff, out_pos_z_ff;
   logic [NORMAL_W-1:0] out_normal_ff;
   logic [TEX_W-1:0]    out_tex_u_ff, out_tex_v_ff;
   logic [COLOR_W-1:0]  out_color_ff;
   logic                out_quad_ff, out_last_ff;
   logic [INDEX_W-1:0]  out_index_a_ff, out_index_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= EXT_RESET;
         height_ff      <= EXT_RESET;
         depth_ff       <= EXT_RESET;
         segs_x_ff      <= SEG_RESET;
         segs_y_ff      <= SEG_RESET;
         segs_z_ff      <= SEG_RESET;
         color_count_ff <= COLOR_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_WIDTH:   width_ff       <= csr_data[EXT_W-1:0];
            CSR_BOX_HEIGHT:  height_ff      <= csr_data[EXT_W-1:0];
            CSR_BOX_DEPTH:   depth_ff       <= csr_data[EXT_W-1:0];
            CSR_SEGMENTS_X:  segs_x_ff      <= csr_data[SEG_CFG_W-1:0];
            CSR_SEGMENTS_Y:  segs_y_ff      <= csr_data[SEG_CFG_W-1:0];
            CSR_SEGMENTS_Z:  segs_z_ff      <= csr_data[SEG_CFG_W-1:0];
            CSR_COLOR_COUNT: color_count_ff <= csr_data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Per-axis extents and clamped segment counts.
   logic [EXT_W-1:0] ext_axis [3];
   logic [SEG_W-1:0] seg_axis [3];

   always_comb begin
      ext_axis[0] = width_ff;
      ext_axis[1] = height_ff;
      ext_axis[2] = depth_ff;
      seg_axis[0] = clamp_seg(segs_x_ff);
      seg_axis[1] = clamp_seg(segs_y_ff);
      seg_axis[2] = clamp_seg(segs_z_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         restart_ff <= req_restart;
      end
   end

   // Load step: apply restart, pick the face and saturate column and row.
   logic [FACE_W-1:0]  eff_face;
   logic [SEG_W-1:0]   eff_col, eff_row, eff_gx, eff_gy;
   logic [INDEX_W-1:0] eff_base;
   face_desc_type      eff_desc;

   always_comb begin
      eff_face = face_ff;
      eff_col  = column_ff;
      eff_row  = row_ff;
      eff_base = base_ff;
      if (restart_ff) begin
         eff_face = FACE_FIRST;
         eff_col  = '0;
         eff_row  = '0;
         eff_base = '0;
      end
      if (eff_face > FACE_LAST) begin
         eff_face = FACE_FIRST;
      end
      eff_desc = face_lookup(eff_face);
      eff_gx   = seg_axis[eff_desc.ua];
      eff_gy   = seg_axis[eff_desc.va];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         face_cur_ff <= eff_face;
         desc_ff     <= eff_desc;
         gx_ff       <= eff_gx;
         gy_ff       <= eff_gy;
         ix_ff       <= (eff_col > eff_gx) ? eff_gx : eff_col;
         iy_ff       <= (eff_row > eff_gy) ? eff_gy : eff_row;
         base_cur_ff <= eff_base;
         e_u_ff      <= ext_axis[eff_desc.ua];
         e_v_ff      <= ext_axis[eff_desc.va];
         e_w_ff      <= ext_axis[eff_desc.wa];
      end
   end

   // Misc step: signs, normal coordinate and code, indices, color slot and next walk position.
   logic [SEG_W:0]      two_ix, two_iy, gx_ext, gy_ext, gx1, gy1;
   logic                below_u, below_v, normal_neg, quad_c;
   logic [SEG_W:0]      diff_u_c, diff_v_c;
   logic [EXT_W:0]      half_sum;
   logic [POS_W-1:0]    half_w, pos_w_c;
   logic [ROW_W-1:0]    row_off, face_size;
   logic [INDEX_W-1:0]  index_a_c;
   logic [FACE_W-1:0]   next_face_c;
   logic [SEG_W-1:0]    next_col_c, next_row_c;
   logic [INDEX_W-1:0]  next_base_c;
   logic [COLOR_W-1:0]  color_c;

   always_comb begin
      two_ix   = {ix_ff, 1'b0};
      two_iy   = {iy_ff, 1'b0};
      gx_ext   = {1'b0, gx_ff};
      gy_ext   = {1'b0, gy_ff};
      gx1      = gx_ext + (SEG_W+1)'(1);
      gy1      = gy_ext + (SEG_W+1)'(1);
      below_u  = (two_ix < gx_ext);
      below_v  = (two_iy < gy_ext);
      diff_u_c = below_u ? (gx_ext - two_ix) : (two_ix - gx_ext);
      diff_v_c = below_v ? (gy_ext - two_iy) : (two_iy - gy_ext);

      // Half extent rounded away from zero.
      half_sum = {1'b0, e_w_ff} + (EXT_W+1)'(1);
      half_w   = half_sum[EXT_W:1];
      if (desc_ff.w_neg) begin
         pos_w_c = -half_w;
      end else if (half_w > POS_MAX) begin
         pos_w_c = POS_MAX;
      end else begin
         pos_w_c = half_w;
      end
      // A face of zero extent reports a negative normal.
      normal_neg = desc_ff.w_neg || (e_w_ff == '0);

      quad_c    = (ix_ff < gx_ff) && (iy_ff < gy_ff);
      row_off   = ROW_W'(gx1) * ROW_W'(iy_ff);
      face_size = ROW_W'(gx1) * ROW_W'(gy1);
      index_a_c = base_cur_ff + INDEX_W'(ix_ff) + INDEX_W'(row_off);

      next_face_c = face_cur_ff;
      next_base_c = base_cur_ff;
      next_row_c  = iy_ff;
      if (ix_ff < gx_ff) begin
         next_col_c = ix_ff + SEG_W'(1);
      end else begin
         next_col_c = '0;
         if (iy_ff < gy_ff) begin
            next_row_c = iy_ff + SEG_W'(1);
         end else begin
            next_row_c = '0;
            if (face_cur_ff >= FACE_LAST) begin
               next_face_c = FACE_FIRST;
               next_base_c = '0;
            end else begin
               next_face_c = face_cur_ff + FACE_W'(1);
               next_base_c = base_cur_ff + INDEX_W'(face_size);
            end
         end
      end

      if (color_count_ff >= COLOR_PER_FACE) begin
         color_c = face_cur_ff;
      end else if (color_count_ff != '0) begin
         color_c = '0;
      end else begin
         color_c = COLOR_GRAY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.misc) begin
         diff_u_ff    <= diff_u_c[SEG_W-1:0];
         diff_v_ff    <= diff_v_c[SEG_W-1:0];
         neg_u_ff     <= below_u ^ desc_ff.u_neg;
         neg_v_ff     <= below_v ^ desc_ff.v_neg;
         pos_w_ff     <= pos_w_c;
         normal_ff    <= {desc_ff.wa, normal_neg};
         quad_ff      <= quad_c;
         index_a_ff   <= quad_c ? index_a_c : '0;
         index_b_ff   <= quad_c ? (index_a_c + INDEX_W'(gx1)) : '0;
         last_ff      <= (face_cur_ff == FACE_LAST) && (ix_ff == gx_ff) && (iy_ff == gy_ff);
         color_ff     <= color_c;
         next_face_ff <= next_face_c;
         next_col_ff  <= next_col_c;
         next_row_ff  <= next_row_c;
         next_base_ff <= next_base_c;
      end
   end

   // Divider operands. Positions divide |2k-g|*e + g by 2g; texture values
   // divide n*65536 + g by 2g. Both round half away from zero.
   logic [SEG_W-1:0]  op_g, op_k;
   logic [EXT_W-1:0]  op_e;
   logic              op_frac;
   logic [NUM_W-1:0]  div_dividend;
   logic [DEN_W-1:0]  div_divisor;
   logic              div_busy;
   logic [QUO_W-1:0]  div_quotient;

   always_comb begin
      case (cmd.op)
         OP_POS_U: begin
            op_g    = gx_ff;
            op_k    = diff_u_ff;
            op_e    = e_u_ff;
            op_frac = 1'b0;
         end
         OP_POS_V: begin
            op_g    = gy_ff;
            op_k    = diff_v_ff;
            op_e    = e_v_ff;
            op_frac = 1'b0;
         end
         OP_TEX_U: begin
            op_g    = gx_ff;
            op_k    = ix_ff;
            op_e    = '0;
            op_frac = 1'b1;
         end
         default: begin
            op_g    = gy_ff;
            op_k    = gy_ff - iy_ff;
            op_e    = '0;
            op_frac = 1'b1;
         end
      endcase
      if (op_frac) begin
         div_dividend = (NUM_W'(op_k) << FRAC_SHIFT) + NUM_W'(op_g);
      end else begin
         div_dividend = NUM_W'(PROD_W'(op_k) * PROD_W'(op_e)) + NUM_W'(op_g);
      end
      div_divisor = {op_g, 1'b0};
   end

   bmvg_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.op)
            OP_POS_U: pos_u_ff <= signed_pos(div_quotient, neg_u_ff);
            OP_POS_V: pos_v_ff <= signed_pos(div_quotient, neg_v_ff);
            OP_TEX_U: tex_u_ff <= div_quotient[TEX_W-1:0];
            default:  tex_v_ff <= div_quotient[TEX_W-1:0];
         endcase
      end
   end

   // Commit: load the output register and advance the walk.
   logic [POS_W-1:0] axis_pos [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (desc_ff.ua == axis_type'(i)) begin
            axis_pos[i] = pos_u_ff;
         end else if (desc_ff.va == axis_type'(i)) begin
            axis_pos[i] = pos_v_ff;
         end else begin
            axis_pos[i] = pos_w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_ff   <= FACE_FIRST;
         column_ff <= '0;
         row_ff    <= '0;
         base_ff   <= '0;
      end else if (cmd.commit) begin
         face_ff   <= next_face_ff;
         column_ff <= next_col_ff;
         row_ff    <= next_row_ff;
         base_ff   <= next_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_pos_x_ff   <= axis_pos[0];
         out_pos_y_ff   <= axis_pos[1];
         out_pos_z_ff   <= axis_pos[2];
         out_normal_ff  <= normal_ff;
         out_tex_u_ff   <= tex_u_ff;
         out_tex_v_ff   <= tex_v_ff;
         out_color_ff   <= color_ff;
         out_quad_ff    <= quad_ff;
         out_index_a_ff <= index_a_ff;
         out_index_b_ff <= index_b_ff;
         out_last_ff    <= last_ff;
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = out_pos_x_ff;
   assign rsp_pos_y       = out_pos_y_ff;
   assign rsp_pos_z       = out_pos_z_ff;
   assign rsp_normal_code = out_normal_ff;
   assign rsp_tex_u       = out_tex_u_ff;
   assign rsp_tex_v       = out_tex_v_ff;
   assign rsp_color_slot  = out_color_ff;
   assign rsp_quad_valid  = out_quad_ff;
   assign rsp_index_a     = out_index_a_ff;
   assign rsp_index_b     = out_index_b_ff;
   assign rsp_last_vertex = out_last_ff;

endmodule

FILE: rtl/core/box_mesh_vertex_generator_top.sv
`timescale 1ns / 1ps
// Top level of the segmented box vertex generator.
//
// Each request transaction on req_ (valid/stall) yields one vertex on rsp_
// (valid/stall). Vertices come face by face (+x, -x, +y, -y, +z, -z), each
// face a grid walked row by row; req_restart set starts over at +x.
// The csr_ channel writes the box extents, segment counts and color count;
// csr_ready is always high, and writes belong to times when no vertex is
// in flight. Unknown register indexes are ignored.
// A request passes through the load and misc steps and four divisions to the finish state,
// where its vertex enters the output register. A new request is taken only once the
// sequencer is idle again; the shared 17-step divider runs four times per vertex (two
// positions and two texture coordinates) behind the load and misc steps.
// A new request is taken while a finished vertex still waits in the output
// register; if the receiver keeps stalling, the next vertex holds in the
// datapath until the output register frees, and req_stall stays high.
// Synchronous reset restores the register reset values, clears the walk to
// the first vertex of +x and empties the output register.
module box_mesh_vertex_generator_top #(
   parameter int MAX_SEGMENTS = bmvg_pkg::DEF_MAX_SEGMENTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [bmvg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic [bmvg_pkg::NORMAL_W-1:0]        rsp_normal_code,
   output logic [bmvg_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [bmvg_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic [bmvg_pkg::COLOR_W-1:0]         rsp_color_slot,
   output logic                                 rsp_quad_valid,
   output logic [bmvg_pkg::INDEX_W-1:0]         rsp_index_a,
   output logic [bmvg_pkg::INDEX_W-1:0]         rsp_index_b,
   output logic                                 rsp_last_vertex,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmvg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bmvg_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bmvg_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bmvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bmvg_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_restart     (req_restart),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_normal_code (rsp_normal_code),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_color_slot  (rsp_color_slot),
      .rsp_quad_valid  (rsp_quad_valid),
      .rsp_index_a     (rsp_index_a),
      .rsp_index_b     (rsp_index_b),
      .rsp_last_vertex (rsp_last_vertex)
   );

   // A taken request keeps the sequencer busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but sequencer not busy");

   // A new vertex only appears out of the busy sequencer.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("vertex presented without a vertex in work");

   // Vertices that anchor no quad carry zero indices.
   a_no_quad_indices: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_quad_valid) |-> (rsp_index_a == '0 && rsp_index_b == '0))
      else $error("index fields set on a vertex without a quad");

   // The final vertex is the far corner of the -z face.
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_vertex) |->
         (rsp_normal_code == NORMAL_NEG_Z && rsp_tex_u == TEX_ONE && rsp_tex_v == '0
          && !rsp_quad_valid))
      else $error("last vertex flag on a vertex that is not the final corner");

endmodule
